/* hw/rtl/umq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umq_pkg
// shared types and constants of the uart message queue framer
// ----------------------------------------------------------------------------
package umq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int MESSAGE_BYTES_DEF = 32;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST = 1'd1;

    localparam logic [7:0] STOP_RESET    = 8'd13;
    localparam logic [7:0] REQUEST_RESET = 8'h26;

    localparam int LEN_W = 6;

    typedef enum logic [1:0] {
        OP_RX    = 2'd0,
        OP_QUEUE = 2'd1,
        OP_TXRDY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_READ = 1'b1
    } back_state_t;

    // classified item passed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic       is_stop;
    } item_t;

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             frame_done;
        logic [LEN_W-1:0] frame_length;
        logic             frame_is_request;
        logic             queue_full;
        logic             receiving;
        logic             sending;
    } result_t;

endpackage

/* hw/rtl/umq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umq channel interfaces
// item channel into the framer and result channel out of it
// ----------------------------------------------------------------------------
interface umq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_of_message;

    modport source (output valid, output operation, output data_byte,
                    output last_of_message, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input last_of_message, output ready);
endinterface

interface umq_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_done;
    logic [5:0] frame_length;
    logic       frame_is_request;
    logic       queue_full;
    logic       receiving;
    logic       sending;

    modport source (output valid, output tx_valid, output tx_byte, output frame_done,
                    output frame_length, output frame_is_request, output queue_full,
                    output receiving, output sending, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input frame_done,
                    input frame_length, input frame_is_request, input queue_full,
                    input receiving, input sending, output ready);
endinterface

/* hw/rtl/umq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umq_front
// accepts items and classifies them for the back end
// ----------------------------------------------------------------------------
module umq_front (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [7:0]            data_byte,
    input  logic                  last_of_message,
    input  logic [7:0]            stop_byte,
    output logic                  push,
    output umq_pkg::item_t        push_item,
    input  logic                  push_ready
);

    assign in_ready = push_ready;
    assign push     = in_valid & push_ready;

    always_comb
    begin
        push_item.op      = umq_pkg::op_t'(operation);
        push_item.data    = data_byte;
        push_item.last    = last_of_message;
        // stop detect only matters for received line bytes
        push_item.is_stop = (umq_pkg::op_t'(operation) == umq_pkg::OP_RX)
                            && (data_byte == stop_byte);
    end

endmodule

/* hw/rtl/umq_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umq_queue
// two-entry item queue between front and back
// ----------------------------------------------------------------------------
module umq_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  umq_pkg::item_t push_item,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output umq_pkg::item_t pop_item
);

    umq_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hw/rtl/umq_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umq_back
// executes items: frame counting, message ring and transmit sequencing
// ----------------------------------------------------------------------------
module umq_back #(
    parameter int QUEUE_DEPTH   = umq_pkg::QUEUE_DEPTH_DEF,
    parameter int MESSAGE_BYTES = umq_pkg::MESSAGE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  umq_pkg::item_t   q_item,
    output logic             q_pop,
    input  logic [7:0]       request_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output umq_pkg::result_t out_result
);

    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int POS_W   = $clog2(MESSAGE_BYTES + 1);
    localparam int DEPTH   = QUEUE_DEPTH * MESSAGE_BYTES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEN_CAP = (MESSAGE_BYTES < 63) ? MESSAGE_BYTES : 63;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [POS_W-1:0]  p);
        slot_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(MESSAGE_BYTES)) + ADDR_W'(p);
    endfunction

    // message store and per-slot lengths
    logic [7:0]       mem [DEPTH];
    logic [POS_W-1:0] len_mem [QUEUE_DEPTH];
    logic [7:0]       rdata_reg;

    umq_pkg::back_state_t state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [POS_W-1:0]  send_pos_reg, send_pos_next;
    logic [POS_W-1:0]  write_pos_reg, write_pos_next;
    logic [POS_W-1:0]  recv_count_reg, recv_count_next;
    logic [7:0]        recv_first_reg, recv_first_next;
    logic              send_active_reg, send_active_next;
    logic              write_drop_reg, write_drop_next;
    logic              recv_active_reg, recv_active_next;
    logic              out_valid_reg, out_valid_next;
    umq_pkg::result_t  out_reg, out_next;
    umq_pkg::result_t  pend_reg, pend_next;
    logic              fwd_reg;
    logic [7:0]        fwd_byte_reg;

    logic              exec;
    logic              emit;
    logic              mem_we, mem_re, len_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [POS_W-1:0]  len_wdata;
    umq_pkg::result_t  res;

    assign exec       = (state_reg == umq_pkg::BK_EXEC) && q_valid
                        && (!out_valid_reg || out_ready);
    assign q_pop      = exec;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb
    begin
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] t2;
        logic [POS_W:0]    len_full;
        logic [POS_W-1:0]  wpv;
        logic [7:0]        first;
        logic              drop;

        nxt      = next_slot(head_reg);
        t2       = next_slot(tail_reg);
        len_full = {1'b0, recv_count_reg} + 1'b1;
        wpv      = write_pos_reg;
        first    = recv_first_reg;
        drop     = 1'b0;

        head_next        = head_reg;
        tail_next        = tail_reg;
        send_pos_next    = send_pos_reg;
        write_pos_next   = write_pos_reg;
        recv_count_next  = recv_count_reg;
        recv_first_next  = recv_first_reg;
        send_active_next = send_active_reg;
        write_drop_next  = write_drop_reg;
        recv_active_next = recv_active_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        len_we    = 1'b0;
        waddr     = slot_addr(head_reg, write_pos_reg);
        raddr     = slot_addr(tail_reg, send_pos_reg);
        len_wdata = write_pos_reg;
        emit      = 1'b0;
        res       = '0;

        if (exec)
        begin
            case (q_item.op)
                umq_pkg::OP_RX:
                begin
                    if (q_item.is_stop)
                    begin
                        if (recv_count_reg == '0)
                            first = q_item.data;
                        if (len_full > (POS_W + 1)'(LEN_CAP))
                            len_full = (POS_W + 1)'(LEN_CAP);
                        res.frame_done       = 1'b1;
                        res.frame_length     = umq_pkg::LEN_W'(len_full);
                        res.frame_is_request = (first == request_byte);
                        recv_count_next      = '0;
                        recv_active_next     = 1'b0;
                    end
                    else
                    begin
                        if (recv_count_reg == '0)
                            recv_first_next = q_item.data;
                        if (recv_count_reg < POS_W'(MESSAGE_BYTES))
                            recv_count_next = recv_count_reg + 1'b1;
                        recv_active_next = 1'b1;
                    end
                end
                umq_pkg::OP_QUEUE:
                begin
                    // ring full is judged at the first byte of a message
                    drop = write_drop_reg || (write_pos_reg == '0 && nxt == tail_reg);
                    if (drop)
                    begin
                        res.queue_full  = 1'b1;
                        write_drop_next = !q_item.last;
                        if (q_item.last)
                            write_pos_next = '0;
                    end
                    else
                    begin
                        if (write_pos_reg < POS_W'(MESSAGE_BYTES))
                        begin
                            mem_we = 1'b1;
                            wpv    = write_pos_reg + 1'b1;
                        end
                        write_pos_next = wpv;
                        if (q_item.last)
                        begin
                            len_we         = 1'b1;
                            len_wdata      = wpv;
                            write_pos_next = '0;
                            head_next      = nxt;
                            if (!send_active_reg && !recv_active_reg)
                            begin
                                send_active_next = 1'b1;
                                send_pos_next    = POS_W'(1);
                                raddr            = slot_addr(tail_reg, '0);
                                emit             = 1'b1;
                            end
                        end
                    end
                end
                umq_pkg::OP_TXRDY:
                begin
                    if (send_active_reg)
                    begin
                        if (send_pos_reg < len_mem[tail_reg])
                        begin
                            send_pos_next = send_pos_reg + 1'b1;
                            emit          = 1'b1;
                        end
                        else
                        begin
                            tail_next = t2;
                            if (t2 == head_reg)
                            begin
                                send_active_next = 1'b0;
                                send_pos_next    = '0;
                            end
                            else
                            begin
                                send_pos_next = POS_W'(1);
                                raddr         = slot_addr(t2, '0);
                                emit          = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        mem_re        = emit;
        res.tx_valid  = emit;
        res.receiving = recv_active_next;
        res.sending   = send_active_next;
    end

    // result register and read sequencing
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            umq_pkg::BK_EXEC:
            begin
                if (exec)
                begin
                    if (emit)
                    begin
                        pend_next  = res;
                        state_next = umq_pkg::BK_READ;
                    end
                    else
                    begin
                        out_next       = res;
                        out_valid_next = 1'b1;
                    end
                end
            end
            umq_pkg::BK_READ:
            begin
                out_next         = pend_reg;
                out_next.tx_byte = fwd_reg ? fwd_byte_reg : rdata_reg;
                out_valid_next   = 1'b1;
                state_next       = umq_pkg::BK_EXEC;
            end
            default:
            begin
                state_next = umq_pkg::BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= umq_pkg::BK_EXEC;
            head_reg        <= '0;
            tail_reg        <= '0;
            send_pos_reg    <= '0;
            write_pos_reg   <= '0;
            recv_count_reg  <= '0;
            recv_first_reg  <= '0;
            send_active_reg <= 1'b0;
            write_drop_reg  <= 1'b0;
            recv_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            send_pos_reg    <= send_pos_next;
            write_pos_reg   <= write_pos_next;
            recv_count_reg  <= recv_count_next;
            recv_first_reg  <= recv_first_next;
            send_active_reg <= send_active_next;
            write_drop_reg  <= write_drop_next;
            recv_active_reg <= recv_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
        // a byte written and read in the same cycle comes from the write side
        fwd_reg      <= mem_we && (waddr == raddr);
        fwd_byte_reg <= q_item.data;
        if (mem_we)
            mem[waddr] <= q_item.data;
        if (mem_re)
            rdata_reg <= mem[raddr];
        if (len_we)
            len_mem[head_reg] <= len_wdata;
    end

endmodule

/* hw/rtl/uart_message_queue_framer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_message_queue_framer_unit
// one uart channel's message engine: frame counter, message ring, tx sequencer
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | operation, data_byte, last_of_message
//  rsp     | out | valid/ready   | tx_valid .. sending, one result per item
//  cfg     | in  | cfg_we        | cfg_index, cfg_data (stop, request byte)
//
//  the back end executes one item per cycle while the result register is free;
//  an item that hands a byte to the transmitter holds it for the registered
//  read of the message store; the front is combinational into a two-entry queue:
//  a taken item waits in a queue entry, then its result in the result register
//  reset clears control state only; the message store needs no clearing pass
//  a stalled result register holds the back end; while it has a free entry the queue still takes items
// ----------------------------------------------------------------------------
module uart_message_queue_framer_unit #(
    parameter int QUEUE_DEPTH   = umq_pkg::QUEUE_DEPTH_DEF,
    parameter int MESSAGE_BYTES = umq_pkg::MESSAGE_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    umq_in_if.sink                         req,
    umq_out_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [umq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);

    logic [7:0] stop_reg, stop_next;
    logic [7:0] request_reg, request_next;

    logic             push, push_ready;
    umq_pkg::item_t   push_item;
    logic             q_valid, q_pop;
    umq_pkg::item_t   q_item;
    umq_pkg::result_t result;

    always_comb
    begin
        stop_next    = stop_reg;
        request_next = request_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                umq_pkg::CFG_STOP:    stop_next    = cfg_data;
                umq_pkg::CFG_REQUEST: request_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg    <= umq_pkg::STOP_RESET;
            request_reg <= umq_pkg::REQUEST_RESET;
        end
        else
        begin
            stop_reg    <= stop_next;
            request_reg <= request_next;
        end
    end

    umq_front u_front (
        .in_valid        (req.valid),
        .in_ready        (req.ready),
        .operation       (req.operation),
        .data_byte       (req.data_byte),
        .last_of_message (req.last_of_message),
        .stop_byte       (stop_reg),
        .push            (push),
        .push_item       (push_item),
        .push_ready      (push_ready)
    );

    umq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    umq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .request_byte (request_reg),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_result   (result)
    );

    assign rsp.tx_valid         = result.tx_valid;
    assign rsp.tx_byte          = result.tx_byte;
    assign rsp.frame_done       = result.frame_done;
    assign rsp.frame_length     = result.frame_length;
    assign rsp.frame_is_request = result.frame_is_request;
    assign rsp.queue_full       = result.queue_full;
    assign rsp.receiving        = result.receiving;
    assign rsp.sending          = result.sending;

endmodule

/* hw/rtl/umq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umq_checker
// port-level checks on the framer's result channel
// ----------------------------------------------------------------------------
module umq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic       frame_done,
    input logic [5:0] frame_length,
    input logic       frame_is_request,
    input logic       queue_full,
    input logic       receiving
);

    // frame fields only carry data when a frame completes
    a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !frame_done |-> frame_length == 6'd0 && !frame_is_request)
        else $error("frame fields set without frame_done");

    // a completed frame counts at least its stop byte and ends receiving
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && frame_done |-> frame_length != 6'd0 && !receiving)
        else $error("completed frame with bad length or still receiving");

    // a dropped queue byte cannot also send or close a frame
    a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && queue_full |-> !tx_valid && !frame_done)
        else $error("queue_full together with another event");

    a_tx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !tx_valid |-> tx_byte == 8'd0)
        else $error("tx_byte nonzero without tx_valid");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(frame_length))
        else $error("result changed while stalled");

endmodule

bind uart_message_queue_framer_unit umq_checker u_umq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .tx_valid         (rsp.tx_valid),
    .tx_byte          (rsp.tx_byte),
    .frame_done       (rsp.frame_done),
    .frame_length     (rsp.frame_length),
    .frame_is_request (rsp.frame_is_request),
    .queue_full       (rsp.queue_full),
    .receiving        (rsp.receiving)
);
